// ----- design/fptm_pkg.sv -----
// fptm_pkg: shared types and constants for the frame present timing monitor
// no dependencies; imported by every other module of the block
`default_nettype none

package fptm_pkg;

    // item operation codes carried on the input tuser
    localparam logic [1:0] FUNC_RECORD  = 2'd0;
    localparam logic [1:0] FUNC_TAKE    = 2'd1;
    localparam logic [1:0] FUNC_BLOCKED = 2'd2;

    // microseconds per second, fits in 20 bits
    localparam int          US_W      = 20;
    localparam logic [19:0] US_PER_S  = 20'd1000000;

    // full-width product of a 64-bit tick count and US_PER_S
    localparam int PROD_W = 64 + US_W;

    // duration and gap thresholds in microseconds
    localparam logic [63:0] THR_ONE_MS     = 64'd1000;
    localparam logic [63:0] THR_HALF_FRAME = 64'd8300;
    localparam logic [63:0] THR_GAP_5MS    = 64'd5000;
    localparam logic [63:0] THR_GAP_12MS   = 64'd12000;
    localparam logic [63:0] THR_GAP_20MS   = 64'd20000;

    // stream payload widths
    localparam int IN_W  = 128;
    localparam int OUT_W = 456;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture the incoming item
        logic conv_start;  // start a tick to microsecond conversion
        logic sel_gap;     // convert the frame gap instead of the swap time
        logic upd_dur;     // fold the converted swap time into the stats
        logic upd_gap;     // fold the converted gap into the stats
        logic set_last;    // remember this item's end tick
        logic emit;        // load the result register
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic has_last;    // a previous end tick is stored
        logic out_free;    // result register can take a new item
        logic conv_done;   // conversion result is ready
    } t_dp_status;

endpackage

`default_nettype wire

// ----- design/fptm_conv.sv -----
// fptm_conv: ticks * 1000000 / frequency, saturated to 64 bits
// two 32x20 partial products, then a 64-step restoring divider; uses fptm_pkg
`default_nettype none

module fptm_conv import fptm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_ticks,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [63:0]      o_result
);

    localparam int          STEP_W    = 7;
    localparam logic [6:0]  STEP_LO   = 7'd0;
    localparam logic [6:0]  STEP_HI   = 7'd1;
    localparam logic [6:0]  STEP_SUM  = 7'd2;
    localparam logic [6:0]  STEP_LAST = 7'd66;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [63:0]       r_dvd;       // ticks, then dividend low bits, then quotient
    logic [31:0]       r_div;
    logic [31:0]       r_rem;
    logic              r_sat;
    logic [51:0]       r_prod_lo;
    logic [51:0]       r_prod_hi;

    logic [PROD_W-1:0] prod_sum;
    logic [32:0]       rem_sh;
    logic              fits;

    // full product from the two partial products
    assign prod_sum = {r_prod_hi, 32'd0} + {32'd0, r_prod_lo};

    // one restoring division step
    assign rem_sh = {r_rem, r_dvd[63]};
    assign fits   = (rem_sh >= {1'b0, r_div});

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 7'd1;
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // multiply, then divide one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_ticks;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (r_step == STEP_LO) begin
                r_prod_lo <= 52'(r_dvd[31:0]) * 52'(US_PER_S);
            end else if (r_step == STEP_HI) begin
                r_prod_hi <= 52'(r_dvd[63:32]) * 52'(US_PER_S);
            end else if (r_step == STEP_SUM) begin
                r_dvd <= prod_sum[63:0];
                r_rem <= {12'd0, prod_sum[PROD_W-1:64]};
                r_sat <= ({12'd0, prod_sum[PROD_W-1:64]} >= r_div);
            end else begin
                r_rem <= fits ? 32'(rem_sh - {1'b0, r_div}) : rem_sh[31:0];
                r_dvd <= {r_dvd[62:0], fits};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_sat ? {64{1'b1}} : r_dvd;

endmodule

`default_nettype wire

// ----- design/fptm_stats.sv -----
// fptm_stats: statistics registers, item capture, frequency register, result register
// uses fptm_pkg; fed by fptm_conv results under fptm_ctrl commands
`default_nettype none

module fptm_stats import fptm_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [31:0]      i_cfg_wr_data,
    input  wire logic [1:0]       i_func,
    input  wire logic [IN_W-1:0]  i_data,
    input  wire t_dp_cmd          i_cmd,
    input  wire logic             i_conv_done,
    input  wire logic [63:0]      i_conv_result,
    input  wire logic             i_out_ready,
    output logic [63:0]           o_conv_ticks,
    output logic [31:0]           o_divisor,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    output logic [OUT_W-1:0]      o_out_data
);

    logic [31:0]      r_tps;
    logic [1:0]       r_func;
    logic [63:0]      r_start;
    logic [63:0]      r_end;
    logic [63:0]      r_sum;
    logic [63:0]      r_max;
    logic [31:0]      r_swap_cnt;
    logic [31:0]      r_over_one;
    logic [31:0]      r_over_half;
    logic [31:0]      r_gap_cnt;
    logic [63:0]      r_gap_min;
    logic [31:0]      r_bins [4];
    logic [63:0]      r_last_end;
    logic             r_blocked;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    logic [OUT_W-1:0] n_out_data;
    logic [1:0]       gap_bin;
    logic             out_free;

    // divisor, zero frequency counts as one
    assign o_divisor = (r_tps == 32'd0) ? 32'd1 : r_tps;

    // tick difference to convert
    assign o_conv_ticks = i_cmd.sel_gap ? (r_end - r_last_end) : (r_end - r_start);

    assign out_free = !r_out_valid || i_out_ready;

    assign o_status.has_last  = (r_last_end != 64'd0);
    assign o_status.out_free  = out_free;
    assign o_status.conv_done = i_conv_done;

    // histogram bin of the converted gap
    always_comb begin
        if (i_conv_result < THR_GAP_5MS) begin
            gap_bin = 2'd0;
        end else if (i_conv_result < THR_GAP_12MS) begin
            gap_bin = 2'd1;
        end else if (i_conv_result < THR_GAP_20MS) begin
            gap_bin = 2'd2;
        end else begin
            gap_bin = 2'd3;
        end
    end

    // result for the captured item
    always_comb begin
        n_out_data = '0;
        case (r_func)
            FUNC_TAKE: begin
                n_out_data[63:0]    = r_sum;
                n_out_data[127:64]  = r_max;
                n_out_data[159:128] = r_swap_cnt;
                n_out_data[191:160] = r_over_one;
                n_out_data[223:192] = r_over_half;
                n_out_data[255:224] = r_gap_cnt;
                n_out_data[319:256] = r_gap_min;
                n_out_data[351:320] = r_bins[0];
                n_out_data[383:352] = r_bins[1];
                n_out_data[415:384] = r_bins[2];
                n_out_data[447:416] = r_bins[3];
            end
            FUNC_BLOCKED: begin
                n_out_data[448] = r_blocked;
            end
            default: begin
                n_out_data = '0;
            end
        endcase
    end

    // frequency register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= 32'd1;
        end else if (i_cfg_wr_en) begin
            r_tps <= i_cfg_wr_data;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_start <= i_data[63:0];
            r_end   <= i_data[127:64];
        end
    end

    // statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_max       <= '0;
            r_swap_cnt  <= '0;
            r_over_one  <= '0;
            r_over_half <= '0;
            r_gap_cnt   <= '0;
            r_gap_min   <= '0;
            r_bins[0]   <= '0;
            r_bins[1]   <= '0;
            r_bins[2]   <= '0;
            r_bins[3]   <= '0;
            r_last_end  <= '0;
            r_blocked   <= 1'b0;
        end else begin
            if (i_cmd.upd_dur) begin
                r_sum      <= r_sum + i_conv_result;
                r_swap_cnt <= r_swap_cnt + 32'd1;
                if (i_conv_result > r_max) begin
                    r_max <= i_conv_result;
                end
                if (i_conv_result > THR_ONE_MS) begin
                    r_over_one <= r_over_one + 32'd1;
                    r_blocked  <= 1'b1;
                end
                if (i_conv_result > THR_HALF_FRAME) begin
                    r_over_half <= r_over_half + 32'd1;
                end
            end
            if (i_cmd.upd_gap) begin
                r_gap_cnt        <= r_gap_cnt + 32'd1;
                r_bins[gap_bin]  <= r_bins[gap_bin] + 32'd1;
                if (r_gap_min == 64'd0 || i_conv_result < r_gap_min) begin
                    r_gap_min <= i_conv_result;
                end
            end
            if (i_cmd.set_last) begin
                r_last_end <= r_end;
            end
            // read-and-clear items
            if (i_cmd.emit && r_func == FUNC_TAKE) begin
                r_sum       <= '0;
                r_max       <= '0;
                r_swap_cnt  <= '0;
                r_over_one  <= '0;
                r_over_half <= '0;
                r_gap_cnt   <= '0;
                r_gap_min   <= '0;
                r_bins[0]   <= '0;
                r_bins[1]   <= '0;
                r_bins[2]   <= '0;
                r_bins[3]   <= '0;
            end
            if (i_cmd.emit && r_func == FUNC_BLOCKED) begin
                r_blocked <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ----- design/fptm_ctrl.sv -----
// fptm_ctrl: item sequencing state machine
// uses fptm_pkg; drives the datapath through t_dp_cmd, watches t_dp_status
`default_nettype none

module fptm_ctrl import fptm_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_valid,
    input  wire logic [1:0] i_func,
    input  wire t_dp_status i_status,
    output logic            o_s_ready,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_DUR_GO   = 5'b00010,
        ST_DUR_WAIT = 5'b00100,
        ST_GAP_WAIT = 5'b01000,
        ST_EMIT     = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_func == FUNC_RECORD) ? ST_DUR_GO : ST_EMIT;
                end
            end
            ST_DUR_GO: begin
                o_cmd.conv_start = 1'b1;
                n_state          = ST_DUR_WAIT;
            end
            ST_DUR_WAIT: begin
                if (i_status.conv_done) begin
                    o_cmd.upd_dur = 1'b1;
                    if (i_status.has_last) begin
                        o_cmd.conv_start = 1'b1;
                        o_cmd.sel_gap    = 1'b1;
                        n_state          = ST_GAP_WAIT;
                    end else begin
                        o_cmd.set_last = 1'b1;
                        n_state        = ST_EMIT;
                    end
                end
            end
            ST_GAP_WAIT: begin
                if (i_status.conv_done) begin
                    o_cmd.upd_gap  = 1'b1;
                    o_cmd.set_last = 1'b1;
                    n_state        = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);

endmodule

`default_nettype wire

// ----- design/frame_present_timing_monitor_core.sv -----
// Frame presentation timing monitor. Items arrive one at a time: a record item
// (tuser 0) gives the tick count before and after a buffer swap; a take item
// (tuser 1) returns all statistics and clears them; a blocked item (tuser 2)
// returns the sticky over-1 ms flag and clears it; tuser 3 is ignored and
// answered with zeros. Every item yields exactly one result item. Tick
// differences are scaled by 1000000 and divided by i_cfg_wr_data as last
// written (reset 1, zero acts as one), saturating to 64 bits. Take, blocked
// and ignored items need no conversion. A record item needs one, or two when
// a previous end tick is stored and a frame gap is also measured: each
// conversion runs a shared unit of two partial products and a 64-step
// bit-serial divider. Results wait in an output register, so the next item
// is taken while a result is still unread. Write the frequency only while
// the block is idle.
`default_nettype none

module frame_present_timing_monitor_core import fptm_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // frequency register write
    input  wire logic             i_cfg_wr_en,
    input  wire logic [31:0]      i_cfg_wr_data,
    // input items
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,   // swap_start_ticks[63:0], swap_end_ticks[127:64]
    input  wire logic [1:0]       s_axis_tuser,   // func[1:0]
    // result items
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata    // duration_sum_us[63:0], duration_max_us[127:64],
                                                  // swap_count[159:128], over_one_ms_count[191:160],
                                                  // over_half_period_count[223:192],
                                                  // gap_count[255:224], frame_gap_min[319:256],
                                                  // gaps_below_5ms[351:320], gaps_below_12ms[383:352],
                                                  // gaps_below_20ms[415:384],
                                                  // gaps_at_least_20ms[447:416], blocked_flag[448],
                                                  // zero[455:449]
);

    t_dp_cmd     cmd;
    t_dp_status  status;
    logic        conv_done;
    logic [63:0] conv_result;
    logic [63:0] conv_ticks;
    logic [31:0] divisor;

    // controller
    fptm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_func    (s_axis_tuser),
        .i_status  (status),
        .o_s_ready (s_axis_tready),
        .o_cmd     (cmd)
    );

    // conversion unit
    fptm_conv u_conv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cmd.conv_start),
        .i_ticks   (conv_ticks),
        .i_divisor (divisor),
        .o_done    (conv_done),
        .o_result  (conv_result)
    );

    // statistics and result register
    fptm_stats u_stats (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_func        (s_axis_tuser),
        .i_data        (s_axis_tdata),
        .i_cmd         (cmd),
        .i_conv_done   (conv_done),
        .i_conv_result (conv_result),
        .i_out_ready   (m_axis_tready),
        .o_conv_ticks  (conv_ticks),
        .o_divisor     (divisor),
        .o_status      (status),
        .o_out_valid   (m_axis_tvalid),
        .o_out_data    (m_axis_tdata)
    );

    // one item in flight: no accept right after an accept
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted while previous item in work");

    // a conversion only finishes while an item is in work
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv_done |-> !s_axis_tready)
        else $error("conversion done with no item in work");

    // a conversion never finishes right after it starts
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.conv_start |=> !conv_done)
        else $error("conversion finished too early");

    // an emitted result is presented on the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> m_axis_tvalid)
        else $error("emitted result not presented");

endmodule

`default_nettype wire
